/* rtl/run_length_event_logger_unit_macros.svh */
// Assertion macros for the run-length event logger.
// Used by the top level only; needs a clock and an active-low reset in scope.
`ifndef RUN_LENGTH_EVENT_LOGGER_UNIT_MACROS_SVH
`define RUN_LENGTH_EVENT_LOGGER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLEL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlel: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RLEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlel: next-cycle check failed");

`endif

/* rtl/rlel_pkg.sv */
// Shared constants, codes and control types of the run-length event logger.
// No dependencies.
`timescale 1ns / 1ps

package rlel_pkg;

  localparam int RECORD_COUNT_DEF = 64;
  localparam int GROUP_COUNT_DEF  = 64;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 176;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = 6;
  localparam int GRP_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_GRP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_GRP_OFF  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_READ = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NF_THRESH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_GROUP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NF_CODE    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;  // capture the input request and start the store read
    logic exec;   // carry out the latched command; unless it is CMD_NONE, load the output register
    logic mark;   // append the nearly-full marker record
  } rlel_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic mark_req;  // the latched add calls for a marker record
  } rlel_sts_t;

endpackage

/* rtl/rlel_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rlel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* rtl/rlel_ctrl.sv */
// Sequencer of the run-length event logger: request intake, execution, marker.
// Depends on rlel_pkg.
`timescale 1ns / 1ps

module rlel_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  rlel_pkg::rlel_sts_t sts,
  output rlel_pkg::rlel_ctl_t ctl
);

  import rlel_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MARK = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = sts.mark_req ? S_MARK : S_IDLE;
        end
      end
      S_MARK: begin
        if (sts.out_free) begin
          ctl.mark  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/rlel_dp.sv */
// Datapath of the run-length event logger: configuration, counters, newest-record
// copy, record store and output register. Depends on rlel_pkg and rlel_ram.
`timescale 1ns / 1ps

module rlel_dp #(
  parameter int RECORD_COUNT = rlel_pkg::RECORD_COUNT_DEF,
  parameter int GROUP_COUNT  = rlel_pkg::GROUP_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [rlel_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [rlel_pkg::CMD_W-1:0]       in_tuser,
  input  logic                             cfg_we,
  input  logic [rlel_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlel_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  rlel_pkg::rlel_ctl_t              ctl,
  output rlel_pkg::rlel_sts_t              sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rlel_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [rlel_pkg::STATUS_W-1:0]    out_tuser,
  output logic                             out_tlast
);

  import rlel_pkg::*;

  localparam int FW = $clog2(RECORD_COUNT);
  localparam int CW = (FW > IDX_W) ? FW : IDX_W;
  localparam int RW = GRP_W + 3 * 32;
  localparam logic [FW-1:0] LAST_SLOT = FW'(RECORD_COUNT - 1);

  // Configuration registers.
  logic [63:0]      mask_r;
  logic [IDX_W-1:0] thr_r;
  logic [GRP_W-1:0] self_grp_r;
  logic [31:0]      full_code_r;
  logic [31:0]      nf_code_r;

  // Latched request.
  logic [CMD_W-1:0] lat_cmd_r;
  logic [31:0]      lat_grp_r;
  logic [31:0]      lat_loc_r;
  logic [31:0]      lat_time_r;
  logic [IDX_W-1:0] lat_ridx_r;

  // Counters and a copy of the record in slot fill_r - 1.
  logic [FW-1:0]    fill_r;
  logic [31:0]      total_r;
  logic [GRP_W-1:0] new_grp_r;
  logic [31:0]      new_loc_r;
  logic [31:0]      new_run_r;

  // Output register.
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   o_status_r;
  logic [IDX_W-1:0]      o_slot_r;
  logic [31:0]           o_grp_r;
  logic [31:0]           o_loc_r;
  logic [31:0]           o_time_r;
  logic [31:0]           o_run_r;
  logic [IDX_W-1:0]      o_fill_r;
  logic [31:0]           o_total_r;
  logic                  o_last_r;

  logic [RW-1:0]    rd_data;
  logic [RW-1:0]    wr_data;

  logic [GRP_W-1:0] sel_grp, eff_grp;
  logic [31:0]      sel_loc, eff_loc;
  logic             at_last, match, grp_ok, grp_en, self_ok, add_ok, do_store, load;
  logic [31:0]      run_val;
  logic [FW-1:0]    slot, fill_after;
  logic             hit;
  logic [STATUS_W-1:0] reject_st;

  assign sel_grp = ctl.mark ? self_grp_r : lat_grp_r[GRP_W-1:0];
  assign sel_loc = ctl.mark ? nf_code_r : lat_loc_r;

  // At the last slot the event is replaced by the full marker.
  assign at_last = (fill_r == LAST_SLOT);
  assign eff_grp = at_last ? self_grp_r : sel_grp;
  assign eff_loc = at_last ? full_code_r : sel_loc;

  assign match   = (fill_r != '0) && (new_grp_r == eff_grp) && (new_loc_r == eff_loc);
  assign run_val = match ? ((new_run_r == 32'hFFFF_FFFF) ? new_run_r : new_run_r + 32'd1)
                         : 32'd1;
  assign slot       = match ? fill_r - FW'(1) : fill_r;
  assign fill_after = (!match && !at_last) ? fill_r + FW'(1) : fill_r;

  assign grp_ok  = lat_grp_r < 32'(GROUP_COUNT);
  assign grp_en  = mask_r[lat_grp_r[GRP_W-1:0]];
  assign self_ok = (32'(self_grp_r) < 32'(GROUP_COUNT)) && mask_r[self_grp_r];
  assign add_ok  = (lat_cmd_r == CMD_ADD) && grp_ok && grp_en;
  assign reject_st = grp_ok ? ST_GRP_OFF : ST_BAD_GRP;

  assign do_store = (ctl.exec && add_ok) || ctl.mark;
  assign load     = (ctl.exec && (lat_cmd_r != CMD_NONE)) || ctl.mark;
  assign hit      = CW'(lat_ridx_r) < CW'(fill_r);

  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.mark_req = add_ok && (CW'(fill_after) == CW'(thr_r)) && self_ok;

  assign wr_data = {eff_grp, eff_loc, lat_time_r, run_val};

  rlel_ram #(
    .WIDTH (RW),
    .DEPTH (RECORD_COUNT)
  ) u_store (
    .clk       (clk),
    .wr_en     (do_store),
    .wr_addr   (slot),
    .wr_data   (wr_data),
    .rd_en     (ctl.latch),
    .rd_addr   (FW'(in_tdata[101:96])),
    .rd_data_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '1;
      thr_r       <= IDX_W'(54);
      self_grp_r  <= '0;
      full_code_r <= 32'd1;
      nf_code_r   <= 32'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUP_MASK: mask_r      <= cfg_wdata;
        REG_NF_THRESH:  thr_r       <= cfg_wdata[IDX_W-1:0];
        REG_SELF_GROUP: self_grp_r  <= cfg_wdata[GRP_W-1:0];
        REG_FULL_CODE:  full_code_r <= cfg_wdata[31:0];
        REG_NF_CODE:    nf_code_r   <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      lat_cmd_r  <= in_tuser;
      lat_grp_r  <= in_tdata[31:0];
      lat_loc_r  <= in_tdata[63:32];
      lat_time_r <= in_tdata[95:64];
      lat_ridx_r <= in_tdata[101:96];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      total_r <= '0;
    end else if (do_store) begin
      fill_r  <= fill_after;
      total_r <= total_r + 32'd1;
    end else if (ctl.exec && (lat_cmd_r == CMD_CLEAR)) begin
      fill_r  <= '0;
      total_r <= '0;
    end
  end

  // A write at the last slot that does not merge leaves slot fill_r - 1 alone.
  always_ff @(posedge clk) begin
    if (do_store && (match || !at_last)) begin
      new_grp_r <= eff_grp;
      new_loc_r <= eff_loc;
      new_run_r <= run_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_status_r <= ST_OK;
      o_slot_r   <= IDX_W'(fill_r);
      o_grp_r    <= '0;
      o_loc_r    <= '0;
      o_time_r   <= '0;
      o_run_r    <= '0;
      o_fill_r   <= IDX_W'(fill_r);
      o_total_r  <= total_r;
      o_last_r   <= 1'b1;
      if (do_store) begin
        o_slot_r  <= IDX_W'(slot);
        o_grp_r   <= 32'(eff_grp);
        o_loc_r   <= eff_loc;
        o_time_r  <= lat_time_r;
        o_run_r   <= run_val;
        o_fill_r  <= IDX_W'(fill_after);
        o_total_r <= total_r + 32'd1;
        o_last_r  <= ctl.mark || !sts.mark_req;
      end else begin
        case (lat_cmd_r)
          CMD_ADD: begin
            o_status_r <= reject_st;
          end
          CMD_CLEAR: begin
            o_slot_r  <= '0;
            o_fill_r  <= '0;
            o_total_r <= '0;
          end
          default: begin
            o_slot_r <= lat_ridx_r;
            if (hit) begin
              o_grp_r  <= 32'(rd_data[RW-1 -: GRP_W]);
              o_loc_r  <= rd_data[95:64];
              o_time_r <= rd_data[63:32];
              o_run_r  <= rd_data[31:0];
            end else begin
              o_status_r <= ST_BAD_READ;
            end
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'd0, o_total_r, o_fill_r, o_run_r, o_time_r, o_loc_r, o_grp_r,
                       o_slot_r};

endmodule

/* rtl/run_length_event_logger_unit.sv */
// Run-length event logger. An accepted request is latched and starts the registered store read;
// it is executed once the output register is free, and any result is then offered from that
// register; a nearly-full marker record follows through a separate marker state. The next
// request is taken only once the last result is loaded; intake waits while the output stalls.
// Synchronous active-low reset restores the register defaults and empties the log; store
// contents are not cleared, and no slot is returned by a read before it is written.
`timescale 1ns / 1ps
`include "run_length_event_logger_unit_macros.svh"

module run_length_event_logger_unit #(
  parameter int RECORD_COUNT = rlel_pkg::RECORD_COUNT_DEF,
  parameter int GROUP_COUNT  = rlel_pkg::GROUP_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // group[31:0], local_code[63:32], time_stamp[95:64], read_index[101:96], zero pad
  input  logic [rlel_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd[1:0]
  input  logic [rlel_pkg::CMD_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // slot[5:0], rec_group[37:6], rec_local[69:38], rec_time[101:70],
  // rec_run_length[133:102], fill_index[139:134], total_count[171:140], zero pad
  output logic [rlel_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status[1:0]
  output logic [rlel_pkg::STATUS_W-1:0]    out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [rlel_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlel_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import rlel_pkg::*;

  rlel_ctl_t ctl;
  rlel_sts_t sts;

  rlel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  rlel_dp #(
    .RECORD_COUNT (RECORD_COUNT),
    .GROUP_COUNT  (GROUP_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // One request at a time: intake closes as soon as a request is taken.
  `RLEL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // A result is only loaded when the output register can take it.
  `RLEL_ASSERT_SAME(a_load_when_free, clk, rst_n, ctl.exec || ctl.mark, sts.out_free)
  // The first result of an add that asks for a marker record is not the last one.
  `RLEL_ASSERT_NEXT(a_mark_after_exec, clk, rst_n, ctl.exec && sts.mark_req, out_tvalid && !out_tlast)
  `RLEL_ASSERT_NEXT(a_no_intake_in_mark, clk, rst_n, ctl.exec && sts.mark_req, !in_tready)

endmodule
